FILE: rtl/core/psv_pkg.sv
// Package for the plucked-string voice: sample and gain types, register
// indexes and reset values, gain clamp helper.
// No dependencies.
package psv_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 17;
  localparam int DLY_W      = 18;
  localparam int CFG_DATA_W = 18;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [DLY_W-1:0]           dly_t;
  typedef logic [2:0]                 cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  // Register indexes
  localparam cfg_index_t CFG_DELAY_LENGTH = 3'd0;
  localparam cfg_index_t CFG_MIX_WEIGHT   = 3'd1;
  localparam cfg_index_t CFG_LOSS_FACTOR  = 3'd2;
  localparam cfg_index_t CFG_POLE_COEF    = 3'd3;
  localparam cfg_index_t CFG_INVERT_MODE  = 3'd4;

  // Reset values
  localparam dly_t  RST_DELAY_LENGTH = 18'd25600;
  localparam gain_t RST_MIX_WEIGHT   = 17'd32768;
  localparam gain_t RST_LOSS_FACTOR  = 17'd65209;
  localparam gain_t RST_POLE_COEF    = 17'd65536;

  localparam gain_t GAIN_ONE = 17'h10000;

  // Gains above unity saturate to unity
  function automatic gain_t gain_clamp(input gain_t g);
    gain_t r;
    r = (g > GAIN_ONE) ? GAIN_ONE : g;
    return r;
  endfunction

endpackage

FILE: rtl/core/psv_excite_if.sv
// Excitation input channel: valid/ready handshake with one sample per beat.
// Depends on psv_pkg.
interface psv_excite_if;
  logic             valid;
  logic             ready;
  psv_pkg::sample_t excite_sample;

  modport source (output valid, output excite_sample, input ready);
  modport sink   (input valid, input excite_sample, output ready);
endinterface

FILE: rtl/core/psv_voice_if.sv
// Voice output channel: valid/ready handshake with one sample per beat.
// Depends on psv_pkg.
interface psv_voice_if;
  logic             valid;
  logic             ready;
  psv_pkg::sample_t voice_sample;

  modport source (output valid, output voice_sample, input ready);
  modport sink   (input valid, input voice_sample, output ready);
endinterface

FILE: rtl/core/plucked_string_synth_voice.sv
// Karplus-Strong string voice: delay store, tap interpolation, mix,
// one-pole lowpass, loss scaling and saturating feedback sum.
// Depends on psv_pkg, psv_excite_if, psv_voice_if.
//
//  channel   dir  beat payload            handshake
//  excite    in   excite_sample (s16)     valid/ready
//  voice     out  voice_sample  (s16)     valid/ready
//  cfg       in   cfg_index, cfg_data     cfg_we, no back-pressure
//
// Steps per sample, in order: an idle step to take the beat, three reads
// of the single-port delay store, five passes through the shared 18x17
// multiplier (each followed by an add step) and a write step, one sample at a time.
// Reset is synchronous; no clearing pass: entries not yet written since
// reset read as zero through the write position and a wrapped flag.
// A result waiting on voice holds the write step until it is taken.
// STORE_DEPTH must be a power of two.
module plucked_string_synth_voice #(
  parameter int STORE_DEPTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  psv_pkg::cfg_index_t   cfg_index,
  input  psv_pkg::cfg_data_t    cfg_data,
  psv_excite_if.sink            excite,
  psv_voice_if.source           voice
);
  import psv_pkg::*;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int POS_W  = ADDR_W + 8;
  localparam int EDLY_W = DLY_W + 1;
  localparam int CW     = (POS_W > EDLY_W) ? POS_W : EDLY_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_MP, S_MC, S_AC,
    S_MW, S_AW, S_MA, S_AA, S_MG, S_WR
  } state_t;

  typedef logic [ADDR_W-1:0] addr_t;

  // Configuration registers
  dly_t  delay_length;
  gain_t mix_weight;
  gain_t loss_factor;
  gain_t pole_coef;
  logic  invert_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length <= RST_DELAY_LENGTH;
      mix_weight   <= RST_MIX_WEIGHT;
      loss_factor  <= RST_LOSS_FACTOR;
      pole_coef    <= RST_POLE_COEF;
      invert_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELAY_LENGTH: delay_length <= cfg_data[DLY_W-1:0];
        CFG_MIX_WEIGHT:   mix_weight   <= gain_clamp(cfg_data[GAIN_W-1:0]);
        CFG_LOSS_FACTOR:  loss_factor  <= gain_clamp(cfg_data[GAIN_W-1:0]);
        CFG_POLE_COEF:    pole_coef    <= gain_clamp(cfg_data[GAIN_W-1:0]);
        CFG_INVERT_MODE:  invert_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control and state registers
  state_t  state;
  addr_t   wp;
  logic    wrapped;
  sample_t lowpass_last;
  logic    out_valid;
  sample_t out_sample;

  // Datapath registers
  sample_t x_q;
  addr_t   idx;
  logic [7:0] frac;
  sample_t rd_q;
  logic    rd_ok;
  sample_t e_prev, e_cur, e_next;
  sample_t tap_prev, tap_cur, mixv;
  logic signed [34:0] prod;

  // Read position: write position minus effective delay, modulo the store
  logic [EDLY_W-1:0] dly_eff;
  logic [CW-1:0]     pos_diff;
  logic [POS_W-1:0]  rp;

  assign dly_eff  = invert_mode ? {delay_length, 1'b0} : {1'b0, delay_length};
  assign pos_diff = CW'({wp, 8'h00}) - CW'(dly_eff);
  assign rp       = pos_diff[POS_W-1:0];

  // Delay store
  sample_t mem [STORE_DEPTH];
  addr_t   rd_addr;
  logic    mem_we;
  logic    rd_fire;
  sample_t sum_sat;

  always_comb begin
    case (state)
      S_RD0:   rd_addr = idx - 1'b1;
      S_RD1:   rd_addr = idx;
      S_RD2:   rd_addr = idx + 1'b1;
      default: rd_addr = idx;
    endcase
  end

  assign rd_fire = (state == S_RD0) || (state == S_RD1) || (state == S_RD2);
  assign mem_we  = (state == S_WR) && (!out_valid || voice.ready);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= sum_sat;
    end else if (rd_fire) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Entries never written since reset read as zero
  always_ff @(posedge clk) begin
    rd_ok <= wrapped || (rd_addr < wp);
  end

  sample_t rd_data;
  assign rd_data = rd_ok ? rd_q : '0;

  // Shared multiplier operands
  gain_t mul_a;
  logic signed [16:0] mul_b;

  always_comb begin
    case (state)
      S_MC: begin
        mul_a = GAIN_W'(frac);
        mul_b = 17'(e_next) - 17'(e_cur);
      end
      S_MW: begin
        mul_a = mix_weight;
        mul_b = 17'(tap_cur) - 17'(tap_prev);
      end
      S_MA: begin
        mul_a = pole_coef;
        mul_b = 17'(mixv) - 17'(lowpass_last);
      end
      // Loss product held while the write step waits
      S_MG, S_WR: begin
        mul_a = loss_factor;
        mul_b = 17'(lowpass_last);
      end
      default: begin
        mul_a = GAIN_W'(frac);
        mul_b = 17'(e_cur) - 17'(e_prev);
      end
    endcase
  end

  // Floor shifts of the registered product
  logic signed [16:0] q8;
  logic signed [16:0] q16;
  assign q8  = prod[24:8];
  assign q16 = prod[32:16];

  // Feedback sum with saturation
  logic signed [17:0] sum_full;
  assign sum_full = invert_mode ? (18'(x_q) + 18'(q16)) : (18'(x_q) - 18'(q16));

  always_comb begin
    if (sum_full > 18'sd32767) begin
      sum_sat = 16'sh7FFF;
    end else if (sum_full < -18'sd32768) begin
      sum_sat = 16'sh8000;
    end else begin
      sum_sat = sum_full[15:0];
    end
  end

  logic signed [16:0] add_base;
  logic signed [16:0] add_sum;
  always_comb begin
    case (state)
      S_MC:    add_base = 17'(e_prev);
      S_AC:    add_base = 17'(e_cur);
      S_AW:    add_base = 17'(tap_prev);
      S_AA:    add_base = 17'(lowpass_last);
      default: add_base = 17'(e_prev);
    endcase
    add_sum = ((state == S_AW) || (state == S_AA)) ? add_base + q16 : add_base + q8;
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, mul_a}) * mul_b;
    case (state)
      S_IDLE: begin
        x_q  <= excite.excite_sample;
        idx  <= rp[POS_W-1:8];
        frac <= rp[7:0];
      end
      S_RD1: e_prev <= rd_data;
      S_RD2: e_cur  <= rd_data;
      S_MP:  e_next <= rd_data;
      S_MC:  tap_prev <= add_sum[15:0];
      S_AC:  tap_cur  <= add_sum[15:0];
      S_AW:  mixv     <= add_sum[15:0];
      default: ;
    endcase
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      wp           <= '0;
      wrapped      <= 1'b0;
      lowpass_last <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && voice.ready && !mem_we) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (excite.valid) state <= S_RD0;
        S_RD0:  state <= S_RD1;
        S_RD1:  state <= S_RD2;
        S_RD2:  state <= S_MP;
        S_MP:   state <= S_MC;
        S_MC:   state <= S_AC;
        S_AC:   state <= S_MW;
        S_MW:   state <= S_AW;
        S_AW:   state <= S_MA;
        S_MA:   state <= S_AA;
        S_AA: begin
          lowpass_last <= add_sum[15:0];
          state        <= S_MG;
        end
        S_MG:   state <= S_WR;
        S_WR: begin
          if (mem_we) begin
            out_valid  <= 1'b1;
            out_sample <= sum_sat;
            wp         <= wp + 1'b1;
            wrapped    <= wrapped | (&wp);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign excite.ready       = (state == S_IDLE);
  assign voice.valid        = out_valid;
  assign voice.voice_sample = out_sample;

endmodule

FILE: rtl/core/psv_checker.sv
// Port-level checks for the plucked-string voice, bound to the top level.
// Depends on psv_pkg and plucked_string_synth_voice.
module psv_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input psv_pkg::sample_t out_sample
);

  // A result waiting on the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("voice beat dropped while stalled");

  // Stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_sample))
    else $error("voice sample changed while stalled");

  // One sample in flight: no new beat taken right after one is accepted
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("excite accepted back to back");

  // Reset leaves the voice ready for input
  a_rst_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("not ready after reset");

  // Reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind plucked_string_synth_voice psv_checker u_psv_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (excite.valid),
  .in_ready   (excite.ready),
  .out_valid  (voice.valid),
  .out_ready  (voice.ready),
  .out_sample (voice.voice_sample)
);
